/* rtl/shared_buffer_multi_queue_unit_macros.svh */
// ----------------------------------------------------------------------------
// shared buffer multi-queue: assertion macros
// concurrent assertion shorthands clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SHARED_BUFFER_MULTI_QUEUE_UNIT_MACROS_SVH
`define SHARED_BUFFER_MULTI_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define SBMQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SBMQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sbmq_pkg.sv */
// ----------------------------------------------------------------------------
// sbmq_pkg
// constants, types and pointer helpers of the shared buffer multi-queue
// ----------------------------------------------------------------------------
package sbmq_pkg;

    localparam int NUM_QUEUES = 4;
    localparam int DEPTH      = 16;
    localparam int DATA_W     = 32;
    localparam int QSEL_W     = 2;
    localparam int SLOT_W     = $clog2(DEPTH);
    localparam int PTR_W      = $clog2(DEPTH + 1);
    localparam int QIDX_W     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    // null pointer code
    localparam logic [PTR_W-1:0] NIL = PTR_W'(DEPTH);

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic                     command;
        logic [QSEL_W-1:0]        queue_index;
        logic signed [DATA_W-1:0] data_in;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_out;
        logic [1:0]               status;
    } rsp_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [PTR_W-1:0]  data;
    } link_wr_t;

    function automatic logic is_slot(input logic [PTR_W-1:0] p);
        return p < NIL;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [PTR_W-1:0] p);
        return p[SLOT_W-1:0];
    endfunction

endpackage

/* rtl/shared_buffer_multi_queue_unit.sv */
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue_unit
// several fifo queues over one shared slot store with a linked free list
// ----------------------------------------------------------------------------
// Each command (enqueue or dequeue on one queue) has an accept step and an
// execute step: the cycle in which start is taken issues the link and data
// memory reads, and the following cycle (busy high) uses the read data,
// writes the links back and registers the result. The result sits on rsp
// for exactly one cycle with done high, in the cycle after busy; start is
// taken again in that same cycle, so commands never overlap (start is
// ignored while busy), as the registered link memory read decides the new
// free-list head or queue head. Every command gives one result transfer;
// there is no back-pressure, the receiver must take it when done is high.
// No clearing pass is needed after reset: the link chain comes from valid
// bits, so start may be raised in the first cycle after reset.
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue_unit
    import sbmq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;

    // queue pointers and free-list head
    logic [PTR_W-1:0] head_reg [NUM_QUEUES];
    logic [PTR_W-1:0] head_next [NUM_QUEUES];
    logic [PTR_W-1:0] tail_reg [NUM_QUEUES];
    logic [PTR_W-1:0] tail_next [NUM_QUEUES];
    logic [PTR_W-1:0] free_head_reg, free_head_next;

    // command held for the execute cycle
    logic              cmd_reg, cmd_next;
    logic [QIDX_W-1:0] qi_reg, qi_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              ok_reg, ok_next;
    logic              was_empty_reg, was_empty_next;

    logic done_reg, done_next;
    rsp_t rsp_reg, rsp_next;

    // accept-cycle decode
    logic              q_ok;
    logic [QIDX_W-1:0] qi_in;
    logic [PTR_W-1:0]  head_sel;
    logic [PTR_W-1:0]  tail_sel;

    // memory ports
    link_wr_t          link_wr;
    logic [SLOT_W-1:0] link_rd_addr;
    logic [PTR_W-1:0]  link_rd;
    logic              data_wr_en;
    logic [SLOT_W-1:0] data_rd_addr;
    logic [DATA_W-1:0] data_rd;

    assign q_ok     = 32'(req.queue_index) < 32'(NUM_QUEUES);
    assign qi_in    = QIDX_W'(req.queue_index);
    assign head_sel = head_reg[qi_in];
    assign tail_sel = tail_reg[qi_in];

    // enqueue reads the free slot's link, dequeue the head slot's link
    assign link_rd_addr = (req.command == CMD_ENQ) ? slot_of(free_head_reg)
                                                    : slot_of(head_sel);
    assign data_rd_addr = slot_of(head_sel);

    // data is written in the accept cycle, straight into the free slot
    assign data_wr_en = start && (state_reg == S_IDLE) && (req.command == CMD_ENQ)
                        && q_ok && is_slot(free_head_reg);

    sbmq_link_store u_link_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (link_wr),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd)
    );

    sbmq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .clk     (clk),
        .wr_en   (data_wr_en),
        .wr_addr (slot_of(free_head_reg)),
        .wr_data (req.data_in),
        .rd_addr (data_rd_addr),
        .rd_data (data_rd)
    );

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_head_next = free_head_reg;
        cmd_next       = cmd_reg;
        qi_next        = qi_reg;
        slot_next      = slot_reg;
        ok_next        = ok_reg;
        was_empty_next = was_empty_reg;
        done_next      = 1'b0;
        rsp_next       = rsp_reg;
        link_wr        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next     = S_EXEC;
                    cmd_next       = req.command;
                    qi_next        = qi_in;
                    was_empty_next = !is_slot(head_sel);
                    if (req.command == CMD_ENQ)
                    begin
                        slot_next = slot_of(free_head_reg);
                        ok_next   = q_ok && is_slot(free_head_reg);
                        // append after a live tail; the read is at another slot
                        if (q_ok && is_slot(free_head_reg) && is_slot(head_sel)
                            && is_slot(tail_sel))
                        begin
                            link_wr.en   = 1'b1;
                            link_wr.addr = slot_of(tail_sel);
                            link_wr.data = free_head_reg;
                        end
                    end
                    else
                    begin
                        slot_next = slot_of(head_sel);
                        ok_next   = q_ok && is_slot(head_sel);
                    end
                end
            end
            S_EXEC:
            begin
                state_next        = S_IDLE;
                done_next         = 1'b1;
                rsp_next.data_out = '0;
                rsp_next.status   = ST_OK;
                if (!ok_reg)
                begin
                    rsp_next.status = (cmd_reg == CMD_ENQ) ? ST_OVERFLOW : ST_UNDERFLOW;
                end
                else if (cmd_reg == CMD_ENQ)
                begin
                    free_head_next   = link_rd;
                    link_wr.en       = 1'b1;
                    link_wr.addr     = slot_reg;
                    link_wr.data     = NIL;
                    tail_next[qi_reg] = PTR_W'(slot_reg);
                    if (was_empty_reg)
                    begin
                        head_next[qi_reg] = PTR_W'(slot_reg);
                    end
                end
                else
                begin
                    // unlink the head and push it onto the free list
                    head_next[qi_reg] = link_rd;
                    link_wr.en        = 1'b1;
                    link_wr.addr      = slot_reg;
                    link_wr.data      = free_head_reg;
                    free_head_next    = PTR_W'(slot_reg);
                    rsp_next.data_out = data_rd;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= NIL;
                tail_reg[i] <= NIL;
            end
            cmd_reg       <= CMD_ENQ;
            qi_reg        <= '0;
            slot_reg      <= '0;
            ok_reg        <= 1'b0;
            was_empty_reg <= 1'b0;
            done_reg      <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            cmd_reg       <= cmd_next;
            qi_reg        <= qi_next;
            slot_reg      <= slot_next;
            ok_reg        <= ok_next;
            was_empty_reg <= was_empty_next;
            done_reg      <= done_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign busy = (state_reg == S_EXEC);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

/* rtl/sbmq_ram.sv */
// ----------------------------------------------------------------------------
// sbmq_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sbmq_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/sbmq_link_store.sv */
// ----------------------------------------------------------------------------
// sbmq_link_store
// slot link memory with per-slot valid bits giving the reset chain
// ----------------------------------------------------------------------------
module sbmq_link_store
    import sbmq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  link_wr_t          wr,
    input  logic [SLOT_W-1:0] rd_addr,
    output logic [PTR_W-1:0]  rd_data
);

    logic [DEPTH-1:0]  valid_reg;
    logic              rd_valid_reg;
    logic [SLOT_W-1:0] rd_addr_reg;
    logic [PTR_W-1:0]  ram_q;

    sbmq_ram #(
        .WIDTH (PTR_W),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_addr_reg  <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
            rd_addr_reg  <= rd_addr;
        end
    end

    // unwritten slot links to the next one, the last one to null
    assign rd_data = rd_valid_reg ? ram_q : PTR_W'(rd_addr_reg) + PTR_W'(1);

endmodule

/* rtl/sbmq_checker.sv */
// ----------------------------------------------------------------------------
// sbmq_checker
// port-level timing and result checks, bound to the top level
// ----------------------------------------------------------------------------
`include "shared_buffer_multi_queue_unit_macros.svh"

module sbmq_checker
    import sbmq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input rsp_t rsp
);

    `SBMQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accept did not go busy")
    `SBMQ_ASSERT_NEXT(a_busy_one_cycle, busy, !busy && done, "busy did not end in a result")
    `SBMQ_ASSERT_NOW(a_done_from_accept, done, $past(start && !busy, 2), "result without command")
    `SBMQ_ASSERT_NOW(a_fail_zero, done && (rsp.status != ST_OK), rsp.data_out == '0, "fail data")
    `SBMQ_ASSERT_NOW(a_status_code, done, rsp.status <= ST_UNDERFLOW, "undefined status code")

endmodule

bind shared_buffer_multi_queue_unit sbmq_checker u_sbmq_checker (.*);
